// ----- rtl/ipv4c_pkg.sv -----
// Shared types, constants and helpers for the IPv4 dotted-decimal text classifier.
package ipv4c_pkg;

    // Longest accepted address string, in characters (legal range 7 to 15)
    localparam int MAX_LEN = 15;

    localparam int CHAR_W   = 8;
    localparam int CLASS_W  = 3;
    localparam int ADDR_W   = 32;
    localparam int OCTET_W  = 10;
    localparam int CCOUNT_W = 5;

    // Upper bounds of the classful ranges, first octet
    localparam logic [7:0] CLASS_A_TOP = 8'd127;
    localparam logic [7:0] CLASS_B_TOP = 8'd191;
    localparam logic [7:0] CLASS_C_TOP = 8'd223;
    localparam logic [7:0] CLASS_D_TOP = 8'd239;
    localparam logic [9:0] OCTET_MAX   = 10'd255;

    localparam logic [CLASS_W-1:0] CLASS_A = 3'd0;
    localparam logic [CLASS_W-1:0] CLASS_B = 3'd1;
    localparam logic [CLASS_W-1:0] CLASS_C = 3'd2;
    localparam logic [CLASS_W-1:0] CLASS_D = 3'd3;
    localparam logic [CLASS_W-1:0] CLASS_E = 3'd4;

    typedef enum logic [1:0] {
        KIND_DIGIT,
        KIND_DOT,
        KIND_OTHER
    } char_kind_t;

    typedef struct packed {
        char_kind_t  kind;
        logic [3:0]  digit;
    } char_info_t;

    typedef struct packed {
        logic                 valid_res;
        logic [CLASS_W-1:0]   ip_class;
        logic [ADDR_W-1:0]    address;
    } parse_result_t;

    function automatic logic [CLASS_W-1:0] class_of(input logic [7:0] first);
        logic [CLASS_W-1:0] cls;
        if (first <= CLASS_A_TOP) cls = CLASS_A;
        else if (first <= CLASS_B_TOP) cls = CLASS_B;
        else if (first <= CLASS_C_TOP) cls = CLASS_C;
        else if (first <= CLASS_D_TOP) cls = CLASS_D;
        else cls = CLASS_E;
        return cls;
    endfunction

endpackage

// ----- rtl/ipv4c_char_decode.sv -----
// Character decoder: sorts one ASCII byte into digit, dot or other.
module ipv4c_char_decode (
    input  logic [ipv4c_pkg::CHAR_W-1:0] character,
    output ipv4c_pkg::char_info_t        info
);
    import ipv4c_pkg::*;

    logic [CHAR_W-1:0] offset;

    assign offset = character - CHAR_W'("0");

    always_comb
    begin
        info.digit = offset[3:0];
        if (character == CHAR_W'(".")) begin
            info.kind = KIND_DOT;
        end
        else if (character >= CHAR_W'("0") && character <= CHAR_W'("9")) begin
            info.kind = KIND_DIGIT;
        end
        else begin
            info.kind = KIND_OTHER;
        end
    end

endmodule

// ----- rtl/ipv4c_octet_parser.sv -----
// Running parse state for one address string and the end-of-string verdict.
module ipv4c_octet_parser (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     step,
    input  ipv4c_pkg::char_info_t    info,
    input  logic                     last,
    output ipv4c_pkg::parse_result_t result
);
    import ipv4c_pkg::*;

    logic [1:0]          octet_index_reg, octet_index_next, octet_index_work;
    logic [1:0]          digit_count_reg, digit_count_next, digit_count_work;
    logic [OCTET_W-1:0]  octet_value_reg, octet_value_next, octet_value_work;
    logic [23:0]         address_so_far_reg, address_so_far_next, address_so_far_work;
    logic [CCOUNT_W-1:0] char_count_reg, char_count_next, char_count_work;
    logic                bad_flag_reg, bad_flag_next, bad_flag_work;
    logic [OCTET_W-1:0]  times_ten;
    logic [ADDR_W-1:0]   full_addr;
    logic                ok;

    // value*10 as two shifts; value is at most 99 here, so no overflow
    assign times_ten = OCTET_W'({octet_value_reg, 3'b000}) + OCTET_W'({octet_value_reg, 1'b0});

    always_comb
    begin
        octet_index_work    = octet_index_reg;
        digit_count_work    = digit_count_reg;
        octet_value_work    = octet_value_reg;
        address_so_far_work = address_so_far_reg;
        char_count_work     = char_count_reg;
        bad_flag_work       = bad_flag_reg;

        if (char_count_reg != '1) begin
            char_count_work = char_count_reg + CCOUNT_W'(1);
        end
        if (char_count_work > CCOUNT_W'(MAX_LEN)) begin
            bad_flag_work = 1'b1;
        end

        case (info.kind)
            KIND_DOT:
            begin
                if (digit_count_reg == 2'd0 || octet_value_reg > OCTET_MAX ||
                    octet_index_reg == 2'd3) begin
                    bad_flag_work = 1'b1;
                end
                if (octet_index_reg != 2'd3) begin
                    address_so_far_work = {address_so_far_reg[15:0], octet_value_reg[7:0]};
                    octet_index_work    = octet_index_reg + 2'd1;
                end
                digit_count_work = 2'd0;
                octet_value_work = '0;
            end
            KIND_DIGIT:
            begin
                if (digit_count_reg == 2'd3) begin
                    bad_flag_work = 1'b1;
                end
                else begin
                    octet_value_work = times_ten + OCTET_W'(info.digit);
                    digit_count_work = digit_count_reg + 2'd1;
                end
            end
            default:
            begin
                bad_flag_work = 1'b1;
            end
        endcase
    end

    assign full_addr = {address_so_far_work, octet_value_work[7:0]};
    assign ok = !bad_flag_work && octet_index_work == 2'd3 && digit_count_work != 2'd0 &&
                octet_value_work <= OCTET_MAX;

    always_comb
    begin
        result.valid_res = ok;
        result.ip_class  = ok ? class_of(full_addr[31:24]) : CLASS_A;
        result.address   = ok ? full_addr : '0;
    end

    // Clear everything after the final character of a string
    always_comb
    begin
        octet_index_next    = octet_index_reg;
        digit_count_next    = digit_count_reg;
        octet_value_next    = octet_value_reg;
        address_so_far_next = address_so_far_reg;
        char_count_next     = char_count_reg;
        bad_flag_next       = bad_flag_reg;
        if (step) begin
            if (last) begin
                octet_index_next    = '0;
                digit_count_next    = '0;
                octet_value_next    = '0;
                address_so_far_next = '0;
                char_count_next     = '0;
                bad_flag_next       = 1'b0;
            end
            else begin
                octet_index_next    = octet_index_work;
                digit_count_next    = digit_count_work;
                octet_value_next    = octet_value_work;
                address_so_far_next = address_so_far_work;
                char_count_next     = char_count_work;
                bad_flag_next       = bad_flag_work;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            octet_index_reg    <= '0;
            digit_count_reg    <= '0;
            octet_value_reg    <= '0;
            address_so_far_reg <= '0;
            char_count_reg     <= '0;
            bad_flag_reg       <= 1'b0;
        end
        else begin
            octet_index_reg    <= octet_index_next;
            digit_count_reg    <= digit_count_next;
            octet_value_reg    <= octet_value_next;
            address_so_far_reg <= address_so_far_next;
            char_count_reg     <= char_count_next;
            bad_flag_reg       <= bad_flag_next;
        end
    end

endmodule

// ----- rtl/ipv4_dotted_text_classifier_unit.sv -----
// Top level: IPv4 dotted-decimal text parser and classful classifier.
// Order: a taken character waits in the input register stage until the result
//   register has room, then is parsed; a last character's verdict is registered.
// Throughput: one character per cycle while the result channel is not stalled.
// Reset (rst_n, async, active low) clears the parse state and both valid flags.
module ipv4_dotted_text_classifier_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    // character channel
    input  logic                                char_valid,
    output logic                                char_stall,
    input  logic [ipv4c_pkg::CHAR_W-1:0]        character,
    input  logic                                last,
    // result channel
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic                                valid_res,
    output logic [ipv4c_pkg::CLASS_W-1:0]       ip_class,
    output logic [ipv4c_pkg::ADDR_W-1:0]        address
);
    import ipv4c_pkg::*;

    // Input register stage
    logic                  s1_valid_reg, s1_valid_next;
    logic [CHAR_W-1:0]     s1_char_reg;
    logic                  s1_last_reg;

    // Result register stage
    logic                  res_valid_reg, res_valid_next;
    parse_result_t         res_reg;

    char_info_t            info;
    parse_result_t         verdict;
    logic                  out_free;
    logic                  step;
    logic                  char_take;

    // The result register can take a new transaction when empty or draining now
    assign out_free   = !res_valid_reg || !result_stall;
    // Parse the held character; every character waits for room so that a
    // last character never has to overwrite an unsent result
    assign step       = s1_valid_reg && out_free;
    assign char_stall = s1_valid_reg && !out_free;
    assign char_take  = char_valid && !char_stall;

    ipv4c_char_decode u_decode (
        .character (s1_char_reg),
        .info      (info)
    );

    ipv4c_octet_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .info   (info),
        .last   (s1_last_reg),
        .result (verdict)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (char_take) begin
            s1_valid_next = 1'b1;
        end
        else if (step) begin
            s1_valid_next = 1'b0;
        end

        res_valid_next = res_valid_reg;
        if (step && s1_last_reg) begin
            res_valid_next = 1'b1;
        end
        else if (res_valid_reg && !result_stall) begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (char_take) begin
            s1_char_reg <= character;
            s1_last_reg <= last;
        end
        if (step && s1_last_reg) begin
            res_reg <= verdict;
        end
    end

    assign result_valid = res_valid_reg;
    assign valid_res    = res_reg.valid_res;
    assign ip_class     = res_reg.ip_class;
    assign address      = res_reg.address;

`ifndef ASSERT_OFF
    // A rejected string carries a zero class and a zero address
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !valid_res |-> ip_class == CLASS_A && address == '0)
        else $error("invalid result with nonzero class or address");

    // Class always agrees with the first octet of a good address
    a_class_match: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && valid_res |-> ip_class == class_of(address[31:24]))
        else $error("class does not match first octet");

    // Parsing a last character always produces a result transaction
    a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
        step && s1_last_reg |=> result_valid)
        else $error("last character did not produce a result");

    // Stall only when a character is held and the output cannot move
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        char_stall |-> s1_valid_reg && result_valid && result_stall)
        else $error("character stall without a blocked result");
`endif

endmodule
